[rtl/bbtc_pkg.sv]
// Shared types and constants for the block buffer tag cache.
`default_nettype none

package bbtc_pkg;

    localparam int SLOT_W  = 5;
    localparam int IDX_W   = 8;
    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;

    localparam logic [TIME_W-1:0] STAMP_NEVER = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX   = '1;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_FAULT  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block_number;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              needs_read;
        logic [1:0]        status;
    } t_rsp;

    // Running scan result handed from cell to cell.
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [CNT_W-1:0]  hit_cnt;
        logic              hit_vld;
        logic              free;
        logic [TIME_W-1:0] best_time;
        logic [IDX_W-1:0]  best_idx;
        logic [CNT_W-1:0]  sel_cnt;
    } t_pkt;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_HIT  = 3'd1,
        ACT_FILL = 3'd2,
        ACT_INC  = 3'd3,
        ACT_DEC  = 3'd4,
        ACT_REL  = 3'd5
    } t_act;

    // Write-back command broadcast to all cells.
    typedef struct packed {
        t_act              act;
        logic [IDX_W-1:0]  idx;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block_number;
        logic [TIME_W-1:0] now;
    } t_upd;

endpackage

`default_nettype wire

[rtl/bbtc_cell.sv]
// One buffer slot: tag, count, valid and stamp, plus its stage of the scan chain.
`default_nettype none

module bbtc_cell import bbtc_pkg::*; #(
    parameter int IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DEV_W-1:0] i_dev,
    input  wire logic [BLK_W-1:0] i_blk,
    input  wire logic [IDX_W-1:0] i_sel,
    input  wire t_pkt             i_pkt,
    input  wire t_upd             i_upd,
    output t_pkt                  o_pkt
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DEV_W-1:0]  r_dev;
    logic [BLK_W-1:0]  r_blk;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_time;
    logic              r_vld;
    logic [DEV_W-1:0]  n_dev;
    logic [BLK_W-1:0]  n_blk;
    logic [CNT_W-1:0]  n_cnt;
    logic [TIME_W-1:0] n_time;
    logic              n_vld;
    t_pkt              r_pkt;
    t_pkt              n_pkt;

    // Fold this slot into the running scan result.
    always_comb begin
        n_pkt = i_pkt;
        if (!i_pkt.hit && r_dev == i_dev && r_blk == i_blk) begin
            n_pkt.hit     = 1'b1;
            n_pkt.hit_idx = MY_IDX;
            n_pkt.hit_cnt = r_cnt;
            n_pkt.hit_vld = r_vld;
        end
        if (r_cnt == '0 && r_time < i_pkt.best_time) begin
            n_pkt.free      = 1'b1;
            n_pkt.best_time = r_time;
            n_pkt.best_idx  = MY_IDX;
        end
        if (i_sel == MY_IDX) begin
            n_pkt.sel_cnt = r_cnt;
        end
    end

    always_comb begin
        n_dev  = r_dev;
        n_blk  = r_blk;
        n_cnt  = r_cnt;
        n_time = r_time;
        n_vld  = r_vld;
        if (i_upd.idx == MY_IDX) begin
            unique case (i_upd.act)
                ACT_HIT: begin
                    n_cnt = r_cnt + CNT_W'(1);
                    n_vld = 1'b1;
                end
                ACT_FILL: begin
                    n_dev = i_upd.device;
                    n_blk = i_upd.block_number;
                    n_cnt = CNT_W'(1);
                    n_vld = 1'b1;
                end
                ACT_INC: n_cnt = r_cnt + CNT_W'(1);
                ACT_DEC: n_cnt = r_cnt - CNT_W'(1);
                ACT_REL: begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_time = i_upd.now;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev  <= '0;
            r_blk  <= '0;
            r_cnt  <= '0;
            r_time <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_dev  <= n_dev;
            r_blk  <= n_blk;
            r_cnt  <= n_cnt;
            r_time <= n_time;
            r_vld  <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
    end

    assign o_pkt = r_pkt;

endmodule

`default_nettype wire

[rtl/block_buffer_tag_cache_top.sv]
// Top level of the block buffer tag cache: request control and the row of slot cells.
`default_nettype none

// Fully associative cache of SLOTS buffer slots, each kept in its own cell with
// device/block tag, 8-bit reference count, contents-valid bit and release stamp.
// A request is taken only while the block is idle. It is then held while a scan
// result walks down the row of cells, one cell per clock, gathering the first
// tag match, the least recently released free slot and the count of the named
// slot. When the scan ends the controller decides the outcome and, once the
// response register is free or being drained, writes it back to the one
// affected cell and loads the response register. The block is then idle again
// and takes the next request even while the response still waits on
// i_out_stall. Read: hit increments the count; a miss
// retags the free slot with the smallest stamp below all-ones (lowest index on
// a tie), sets the count to one and reports needs_read. Release/pin/unpin adjust
// the count of a slot; release stamps i_in.now when the count drops to zero.
// Count overflow, underflow or a slot index of SLOTS or more give status fault
// and change nothing; a read with no free slot gives status no-free and slot 0.
module block_buffer_tag_cache_top import bbtc_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out
);

    localparam int CW = $clog2(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    t_req             r_req;
    logic             r_o_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;
    t_upd             w_upd;
    t_act             w_act;
    logic [IDX_W-1:0] w_idx;
    logic             w_accept;
    logic             w_commit;
    logic             w_in_range;
    logic [IDX_W-1:0] w_sel;
    t_pkt             w_start;
    t_pkt             w_res;
    t_pkt             w_chain [0:SLOTS];

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Commit only when the response register is free or being drained.
    assign w_commit = (r_state == S_DONE) && (!r_o_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(SLOTS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_commit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Hold the request for the whole scan.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
        if (w_commit) begin
            r_rsp <= n_rsp;
        end
    end

    // Seed of the scan: no hit, no free slot, best stamp at all-ones.
    always_comb begin
        w_start           = '0;
        w_start.best_time = STAMP_NEVER;
    end

    assign w_sel      = IDX_W'(r_req.slot);
    assign w_chain[0] = w_start;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        bbtc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dev   (r_req.device),
            .i_blk   (r_req.block_number),
            .i_sel   (w_sel),
            .i_pkt   (w_chain[g]),
            .i_upd   (w_upd),
            .o_pkt   (w_chain[g+1])
        );
    end

    assign w_res      = w_chain[SLOTS];
    assign w_in_range = ({{(32-SLOT_W){1'b0}}, r_req.slot} < 32'(SLOTS));

    // Decide the outcome from the finished scan.
    always_comb begin
        w_act          = ACT_NONE;
        w_idx          = w_sel;
        n_rsp.slot_out = r_req.slot;
        n_rsp.needs_read = 1'b0;
        n_rsp.status   = ST_OK;
        if (r_req.op == OP_READ) begin
            if (w_res.hit) begin
                w_idx          = w_res.hit_idx;
                n_rsp.slot_out = w_res.hit_idx[SLOT_W-1:0];
                if (w_res.hit_cnt == COUNT_MAX) begin
                    n_rsp.status = ST_FAULT;
                end else begin
                    w_act            = ACT_HIT;
                    n_rsp.needs_read = !w_res.hit_vld;
                end
            end else if (w_res.free) begin
                w_act            = ACT_FILL;
                w_idx            = w_res.best_idx;
                n_rsp.slot_out   = w_res.best_idx[SLOT_W-1:0];
                n_rsp.needs_read = 1'b1;
            end else begin
                n_rsp.slot_out = '0;
                n_rsp.status   = ST_NOFREE;
            end
        end else if (!w_in_range) begin
            n_rsp.status = ST_FAULT;
        end else if (r_req.op == OP_PIN) begin
            if (w_res.sel_cnt == COUNT_MAX) begin
                n_rsp.status = ST_FAULT;
            end else begin
                w_act = ACT_INC;
            end
        end else begin
            if (w_res.sel_cnt == '0) begin
                n_rsp.status = ST_FAULT;
            end else if (r_req.op == OP_RELEASE) begin
                w_act = ACT_REL;
            end else begin
                w_act = ACT_DEC;
            end
        end
    end

    always_comb begin
        w_upd.act          = w_commit ? w_act : ACT_NONE;
        w_upd.idx          = w_idx;
        w_upd.device       = r_req.device;
        w_upd.block_number = r_req.block_number;
        w_upd.now          = r_req.now;
    end

    assign o_out_valid = r_o_valid;
    assign o_out       = r_rsp;

    // A response appears only after a decision cycle.
    a_rsp_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("response without a finished scan");

    // No free slot reports slot zero and no disk read.
    a_nofree_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_NOFREE) |->
            (o_out.slot_out == '0 && !o_out.needs_read))
        else $error("no-free response carries slot or read flag");

    // A disk read is only requested by a successful request.
    a_read_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.needs_read) |-> (o_out.status == ST_OK))
        else $error("needs_read set on a failed request");

endmodule

`default_nettype wire

[test/block_buffer_tag_cache_top_tb.sv]
// Self-checking testbench for the block buffer tag cache top level.
`timescale 1ns / 100ps

module block_buffer_tag_cache_top_tb import bbtc_pkg::*;;

    localparam int NUM_SLOTS       = 32;
    localparam int KEYS            = 8;
    localparam int MIXED_PER_SEG   = 85;
    localparam int QUIET_LIMIT     = 2000;

    // One row of the directed table: the request, and where the response is
    // obvious from the request alone, the response typed in by hand.
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    t_req i_in       = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out;

    // Shadow copy of the slot table, advanced once per accepted request.
    logic [DEV_W-1:0]  shadow_dev   [NUM_SLOTS];
    logic [BLK_W-1:0]  shadow_blk   [NUM_SLOTS];
    logic [CNT_W-1:0]  shadow_cnt   [NUM_SLOTS];
    logic [TIME_W-1:0] shadow_stamp [NUM_SLOTS];
    logic              shadow_vld   [NUM_SLOTS];

    // Responses owed by the block, oldest first.
    t_rsp rsp_due_q[$];
    t_dir_row directed_q[$];

    logic [DEV_W-1:0] key_dev [KEYS];
    logic [BLK_W-1:0] key_blk [KEYS];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int reqs_sent     = 0;
    int rsps_seen     = 0;
    int err_count     = 0;
    int nofree_seen   = 0;
    int fault_seen    = 0;
    int fills_seen    = 0;
    int quiet_cycles  = 0;

    block_buffer_tag_cache_top #(
        .SLOTS(NUM_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return the response the cache
    // must give for it.
    function automatic t_rsp cache_apply(input t_req r);
        t_rsp              rsp;
        int                hit;
        int                s;
        logic [TIME_W-1:0] best;
        rsp = '0;
        hit = -1;
        if (r.op == OP_READ) begin
            // Lowest matching index wins, reset tags match like any other.
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (hit < 0 && shadow_dev[i] == r.device && shadow_blk[i] == r.block_number)
                    hit = i;
            end
            if (hit >= 0) begin
                if (shadow_cnt[hit] == COUNT_MAX) begin
                    rsp.slot_out = SLOT_W'(hit);
                    rsp.status   = ST_FAULT;
                    return rsp;
                end
                shadow_cnt[hit] = shadow_cnt[hit] + CNT_W'(1);
            end else begin
                // Victim: free slot with the oldest stamp, never an all-ones stamp.
                best = STAMP_NEVER;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (shadow_cnt[i] == '0 && shadow_stamp[i] < best) begin
                        best = shadow_stamp[i];
                        hit  = i;
                    end
                end
                if (hit < 0) begin
                    rsp.status = ST_NOFREE;
                    return rsp;
                end
                shadow_dev[hit] = r.device;
                shadow_blk[hit] = r.block_number;
                shadow_vld[hit] = 1'b0;
                shadow_cnt[hit] = CNT_W'(1);
            end
            rsp.slot_out    = SLOT_W'(hit);
            rsp.needs_read  = !shadow_vld[hit];
            rsp.status      = ST_OK;
            shadow_vld[hit] = 1'b1;
            return rsp;
        end
        s = int'(r.slot);
        rsp.slot_out = r.slot;
        if (s >= NUM_SLOTS) begin
            rsp.status = ST_FAULT;
        end else if (r.op == OP_PIN) begin
            if (shadow_cnt[s] == COUNT_MAX) begin
                rsp.status = ST_FAULT;
            end else begin
                shadow_cnt[s] = shadow_cnt[s] + CNT_W'(1);
                rsp.status    = ST_OK;
            end
        end else begin
            // Release and unpin; only release stamps the final drop.
            if (shadow_cnt[s] == '0) begin
                rsp.status = ST_FAULT;
            end else begin
                shadow_cnt[s] = shadow_cnt[s] - CNT_W'(1);
                if (r.op == OP_RELEASE && shadow_cnt[s] == '0)
                    shadow_stamp[s] = r.now;
                rsp.status = ST_OK;
            end
        end
        return rsp;
    endfunction

    function automatic bit has_free_slot();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (shadow_cnt[i] == '0 && shadow_stamp[i] != STAMP_NEVER)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Pick a slot that holds references, or any slot if none does.
    function automatic logic [SLOT_W-1:0] pick_busy_slot();
        int busy[$];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (shadow_cnt[i] != '0)
                busy.push_back(i);
        end
        if (busy.size() == 0)
            return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        return SLOT_W'(busy[$urandom_range(0, busy.size() - 1)]);
    endfunction

    // Fully random request of the given kind; stamps lean toward ties and all-ones.
    function automatic t_req rand_req(input logic [1:0] op);
        t_req r;
        r.op           = op;
        r.device       = DEV_W'($urandom_range(0, 255));
        r.block_number = $urandom();
        r.slot         = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        case ($urandom_range(0, 15))
            0:       r.now = STAMP_NEVER;
            1, 2:    r.now = TIME_W'($urandom_range(0, 15));
            default: r.now = $urandom();
        endcase
        return r;
    endfunction

    // Mixed traffic: reads mostly from a small key pool so hits happen,
    // releases and unpins mostly aimed at slots that hold references.
    function automatic t_req make_mixed_req();
        t_req r;
        int   sel;
        int   k;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            r = rand_req(OP_READ);
            if ($urandom_range(0, 9) < 7) begin
                k              = $urandom_range(0, KEYS - 1);
                r.device       = key_dev[k];
                r.block_number = key_blk[k];
            end
        end else if (sel < 75) begin
            r = rand_req(OP_RELEASE);
            if ($urandom_range(0, 99) < 85)
                r.slot = pick_busy_slot();
        end else if (sel < 87) begin
            r = rand_req(OP_PIN);
        end else begin
            r = rand_req(OP_UNPIN);
            if ($urandom_range(0, 99) < 85)
                r.slot = pick_busy_slot();
        end
        return r;
    endfunction

    // Present one request, hold it until accepted, then book its response.
    // Idle gaps are long enough to end at any point of the block's scan.
    task automatic send_request(input t_req r, input bit use_typed = 1'b0,
                                input t_rsp typed_rsp = '0);
        t_rsp due;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2 * NUM_SLOTS)) @(posedge i_clk);
        end
        i_in       <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        due = cache_apply(r);
        if (use_typed)
            due = typed_rsp;
        rsp_due_q.push_back(due);
        reqs_sent++;
    endtask

    // Drop valid and hold until every booked response has come back.
    task automatic wait_all_responses();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (reqs_sent != rsps_seen);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [DEV_W-1:0] dev,
                           input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_W-1:0] now, input bit typed,
                           input logic [SLOT_W-1:0] exp_slot, input logic exp_nr,
                           input logic [1:0] exp_st);
        t_dir_row row;
        row.req.op             = op;
        row.req.device         = dev;
        row.req.block_number   = blk;
        row.req.slot           = slot;
        row.req.now            = now;
        row.typed              = typed;
        row.rsp.slot_out       = exp_slot;
        row.rsp.needs_read     = exp_nr;
        row.rsp.status         = exp_st;
        directed_q.push_back(row);
    endtask

    // Read fresh blocks until no slot can be taken, push past it, then free some.
    task automatic fill_until_full();
        int guard;
        guard = 0;
        while (has_free_slot() && guard < 2 * NUM_SLOTS) begin
            send_request(rand_req(OP_READ));
            guard++;
        end
        repeat (2) send_request(rand_req(OP_READ));
        repeat ($urandom_range(8, 24)) begin
            t_req r;
            r      = rand_req(OP_RELEASE);
            r.slot = pick_busy_slot();
            send_request(r);
        end
    endtask

    // Drive one slot's count to the top, push it over on pin and on a read hit,
    // then walk it back to zero and under.
    task automatic saturate_one_slot();
        t_req              r;
        logic [SLOT_W-1:0] s;
        send_request(rand_req(OP_READ));
        s = pick_busy_slot();
        while (shadow_cnt[s] != COUNT_MAX) begin
            r      = rand_req(OP_PIN);
            r.slot = s;
            send_request(r);
        end
        repeat (2) begin
            r      = rand_req(OP_PIN);
            r.slot = s;
            send_request(r);
        end
        r              = rand_req(OP_READ);
        r.device       = shadow_dev[s];
        r.block_number = shadow_blk[s];
        send_request(r);
        while (shadow_cnt[s] != '0) begin
            r      = rand_req(OP_UNPIN);
            r.slot = s;
            send_request(r);
        end
        r      = rand_req(OP_UNPIN);
        r.slot = s;
        send_request(r);
        r      = rand_req(OP_RELEASE);
        r.slot = s;
        send_request(r);
    endtask

    // Response side: check each accepted response against the oldest booking,
    // then pick the stall for the next cycle.
    always @(posedge i_clk) begin : rsp_check
        t_rsp due;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (rsp_due_q.size() == 0) begin
                    $display("%0t: response with none outstanding: %s %0d %0b %0d",
                             $time, "slot/needs_read/status", o_out.slot_out,
                             o_out.needs_read, o_out.status);
                    err_count++;
                end else begin
                    due = rsp_due_q.pop_front();
                    if (o_out.slot_out !== due.slot_out || o_out.needs_read !== due.needs_read ||
                        o_out.status !== due.status) begin
                        $display("%0t: response mismatch: expected slot %0d needs_read %0b %s",
                                 $time, due.slot_out, due.needs_read,
                                 $sformatf("status %0d, got slot %0d needs_read %0b status %0d",
                                           due.status, o_out.slot_out, o_out.needs_read,
                                           o_out.status));
                        err_count++;
                    end
                    if (due.status == ST_NOFREE)
                        nofree_seen++;
                    if (due.status == ST_FAULT)
                        fault_seen++;
                    if (due.status == ST_OK && due.needs_read)
                        fills_seen++;
                end
                rsps_seen <= rsps_seen + 1;
            end
            i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("block_buffer_tag_cache_top_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_dev[i]   = '0;
            shadow_blk[i]   = '0;
            shadow_cnt[i]   = '0;
            shadow_stamp[i] = '0;
            shadow_vld[i]   = 1'b0;
        end

        // Directed table. Typed rows are plain from the request; the rest go
        // through the shadow table.
        // Reset tags are device 0 block 0: first read hits slot 0 and needs a fill.
        add_row(OP_READ,    8'h00, 32'h0000_0000, 5'd0,  32'h0,         1, 5'd0,  1'b1, ST_OK);
        // Count underflow on release and unpin of idle slots.
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd7,  32'h0,         1, 5'd7,  1'b0, ST_FAULT);
        add_row(OP_UNPIN,   8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1, 5'd31, 1'b0, ST_FAULT);
        add_row(OP_PIN,     8'h00, 32'h0000_0000, 5'd31, 32'h0,         1, 5'd31, 1'b0, ST_OK);
        add_row(OP_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 32'h0,         1, 5'd31, 1'b0, ST_OK);
        add_row(OP_READ,    8'h00, 32'h0000_0000, 5'd0,  32'h0,         0, '0, 1'b0, ST_OK);
        add_row(OP_READ,    8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0,         0, '0, 1'b0, ST_OK);
        // Final release with an all-ones stamp: slot 0 must never be a victim.
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'hFFFF_FFFF, 0, '0, 1'b0, ST_OK);
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'hFFFF_FFFF, 0, '0, 1'b0, ST_OK);
        add_row(OP_READ,    8'h5A, 32'h1234_5678, 5'd0,  32'h0,         0, '0, 1'b0, ST_OK);
        // Many slots still carry the reset tag: lowest index hits, already valid.
        add_row(OP_READ,    8'h00, 32'h0000_0000, 5'd0,  32'h0,         0, '0, 1'b0, ST_OK);
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'h0000_0010, 0, '0, 1'b0, ST_OK);
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1,  32'h0000_0008, 0, '0, 1'b0, ST_OK);
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd2,  32'h0000_0008, 0, '0, 1'b0, ST_OK);
        add_row(OP_READ,    8'hA5, 32'hA5A5_A5A5, 5'd31, 32'hFFFF_FFFF, 0, '0, 1'b0, ST_OK);
        add_row(OP_READ,    8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0,         0, '0, 1'b0, ST_OK);
        add_row(OP_PIN,     8'hFF, 32'hFFFF_FFFF, 5'd1,  32'hFFFF_FFFF, 0, '0, 1'b0, ST_OK);
        add_row(OP_UNPIN,   8'h00, 32'h0000_0000, 5'd1,  32'h0,         0, '0, 1'b0, ST_OK);
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1,  32'hFFFF_FFFE, 0, '0, 1'b0, ST_OK);
        add_row(OP_READ,    8'h00, 32'h8000_0000, 5'd0,  32'h0,         0, '0, 1'b0, ST_OK);
        add_row(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 32'h5555_5555, 0, '0, 1'b0, ST_OK);

        // Hold reset, then release it and let the block settle before the first request.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[i])
            send_request(directed_q[i].req, directed_q[i].typed, directed_q[i].rsp);

        // Random part in segments, cycling through the idling phases:
        // none, sender idle, receiver stalling, both.
        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
                1: begin in_idle_pct = 73; out_stall_pct <= 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct <= 73; end
                default: begin in_idle_pct = 38; out_stall_pct <= 38; end
            endcase
            // Halfway through, let the pipe run completely dry once.
            if (seg == 4)
                wait_all_responses();
            for (int k = 0; k < KEYS; k++) begin
                key_dev[k] = DEV_W'($urandom_range(0, 255));
                key_blk[k] = $urandom();
            end
            fill_until_full();
            if (seg == 1)
                saturate_one_slot();
            repeat (MIXED_PER_SEG) send_request(make_mixed_req());
        end

        // Drain, then keep watching for stray responses before the final check.
        wait_all_responses();
        repeat (NUM_SLOTS + 4) @(posedge i_clk);
        if (rsp_due_q.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, rsp_due_q.size());
            err_count++;
        end

        $display("run covered %0d requests over all idling phases:", reqs_sent);
        $display("  %0d fills, %0d no-free, %0d count faults, %0d mismatches",
                 fills_seen, nofree_seen, fault_seen, err_count);
        if (err_count == 0)
            $display("block_buffer_tag_cache_top_tb: clean");
        else
            $display("block_buffer_tag_cache_top_tb: errors");
        $finish;
    end

endmodule

[block_buffer_tag_cache_top.f]
rtl/bbtc_pkg.sv
rtl/bbtc_cell.sv
rtl/block_buffer_tag_cache_top.sv
test/block_buffer_tag_cache_top_tb.sv
